>>> rtl/core/tkm_pkg.sv
// shared constants, types and codes of the timestamp k-way merge
package tkm_pkg;

	localparam int MAX_STREAMS     = 16;
	localparam int KEY_BYTES       = 19;
	localparam int KEY_FIELD_BYTES = 19;
	localparam int KEY_W           = KEY_FIELD_BYTES * 8;
	localparam int STREAM_W        = 4;
	localparam int REQ_W           = 2;
	localparam int HI_W            = 64;
	localparam int MID_W           = 64;
	localparam int LO_W            = 24;
	localparam int CNT_W           = $clog2(MAX_STREAMS + 1);
	localparam int IDX_W           = $clog2(MAX_STREAMS);

	// only the leading KEY_BYTES bytes take part in a compare
	localparam logic [KEY_W-1:0] KEY_MASK =
		{KEY_W{1'b1}} << (8 * (KEY_FIELD_BYTES - KEY_BYTES));

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_STREAMS);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD,
		REQ_START,
		REQ_NEXT,
		REQ_END
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		TBL_NOP,
		TBL_INSERT,
		TBL_POP,
		TBL_REPLACE
	} tbl_op_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [STREAM_W-1:0] stream;
	} wait_entry_t;

	typedef struct packed {
		tbl_op_t          op;
		logic [CNT_W-1:0] pos;
		wait_entry_t      entry;
	} tbl_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		wait_entry_t      head;
		wait_entry_t      rd;
	} tbl_stat_t;

endpackage

>>> rtl/core/tkm_if.sv
// request and result channel interfaces of the timestamp k-way merge
interface tkm_req_if;
	logic                          valid;
	logic                          ready;
	logic [tkm_pkg::REQ_W-1:0]     req_type;
	logic [tkm_pkg::STREAM_W-1:0]  stream_id;
	logic [tkm_pkg::HI_W-1:0]      key_hi;
	logic [tkm_pkg::MID_W-1:0]     key_mid;
	logic [tkm_pkg::LO_W-1:0]      key_lo;

	modport source (output valid, req_type, stream_id, key_hi, key_mid, key_lo, input ready);
	modport sink (input valid, req_type, stream_id, key_hi, key_mid, key_lo, output ready);
endinterface

interface tkm_res_if;
	logic                          valid;
	logic                          ready;
	logic [tkm_pkg::STREAM_W-1:0]  emit_stream;
	logic                          merge_done;

	modport source (output valid, emit_stream, merge_done, input ready);
	modport sink (input valid, emit_stream, merge_done, output ready);
endinterface

>>> rtl/core/tkm_wait_table.sv
// sorted table of waiting streams with shift insert, pop and replace
module tkm_wait_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tkm_pkg::tbl_cmd_t           cmd,
	input  logic [tkm_pkg::IDX_W-1:0]   rd_idx,
	output tkm_pkg::tbl_stat_t          stat
);

	tkm_pkg::wait_entry_t             entries_q [tkm_pkg::MAX_STREAMS];
	logic [tkm_pkg::CNT_W-1:0]        count_q;

	for (genvar g = 0; g < tkm_pkg::MAX_STREAMS; g++) begin : g_ent
		localparam logic [tkm_pkg::CNT_W-1:0] G  = tkm_pkg::CNT_W'(g);
		localparam logic [tkm_pkg::CNT_W-1:0] G1 = tkm_pkg::CNT_W'(g + 1);
		tkm_pkg::wait_entry_t prev_e;
		tkm_pkg::wait_entry_t next_e;

		if (g > 0) begin : g_prev
			assign prev_e = entries_q[g-1];
		end else begin : g_first
			assign prev_e = entries_q[g];
		end
		if (g < tkm_pkg::MAX_STREAMS - 1) begin : g_next
			assign next_e = entries_q[g+1];
		end else begin : g_last
			assign next_e = entries_q[g];
		end

		always_ff @(posedge clk) begin
			case (cmd.op)
				tkm_pkg::TBL_INSERT: begin
					if (G == cmd.pos) begin
						entries_q[g] <= cmd.entry;
					end else if (G > cmd.pos) begin
						entries_q[g] <= prev_e;
					end
				end
				tkm_pkg::TBL_POP: begin
					entries_q[g] <= next_e;
				end
				// insert before pos and drop the head in one step
				tkm_pkg::TBL_REPLACE: begin
					if (G1 == cmd.pos) begin
						entries_q[g] <= cmd.entry;
					end else if (G1 < cmd.pos) begin
						entries_q[g] <= next_e;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				tkm_pkg::TBL_INSERT: count_q <= count_q + 1'b1;
				tkm_pkg::TBL_POP:    count_q <= count_q - 1'b1;
				default:             count_q <= count_q;
			endcase
		end
	end

	assign stat.count = count_q;
	assign stat.head  = entries_q[0];
	assign stat.rd    = entries_q[rd_idx];

endmodule

>>> rtl/core/timestamp_kway_merge.sv
// timestamp k-way merge: picks the next stream to emit from sorted line streams
//
// req channel (valid/ready): load head, start merge, next key of the current
// stream, or current stream ended. res channel (valid/ready): emit_stream and
// merge_done. load items build the sorted table of waiting streams, start names
// the smallest, and each later request names the next stream to emit.
// a single 152-bit key comparator walks the table one entry per cycle; the
// table itself is a shift row, so insert and pop move every entry at once.
// steps per request: start, end and any request that is dropped go from
// accept straight to execute; load and next accept, scan the table up to the
// sorted position p (0 to waiting count, at most MAX_STREAMS - 1), then
// execute. a result shows on res the cycle after execution.
// req.ready is high only while no request is in progress; a new request is
// taken while an earlier result still sits in the output register.
// if the receiver stalls with a result pending, the next request that makes a
// result holds in its execute step until the output register frees.
// reset clears the waiting count, the current stream, the merging flag and
// the output valid flag; the block is ready straight out of reset.
module timestamp_kway_merge (
	input  logic       clk,
	input  logic       arst_n,
	tkm_req_if.sink    req,
	tkm_res_if.source  res
);

	tkm_pkg::state_t                  state_q, state_d;
	tkm_pkg::req_t                    req_q;
	logic [tkm_pkg::STREAM_W-1:0]     sid_q;
	logic [tkm_pkg::KEY_W-1:0]        key_q;
	logic [tkm_pkg::CNT_W-1:0]        idx_q;
	logic [tkm_pkg::STREAM_W-1:0]     cur_q;
	logic                             merging_q;
	logic                             out_valid_q;
	logic [tkm_pkg::STREAM_W-1:0]     out_stream_q;
	logic                             out_done_q;

	tkm_pkg::tbl_cmd_t                tbl_cmd;
	tkm_pkg::tbl_stat_t               tbl_stat;

	tkm_pkg::req_t                    in_req;
	logic                             accept;
	logic                             scan_need;
	logic [tkm_pkg::KEY_W-1:0]        rd_key;
	logic                             key_gt;
	logic                             key_eq;
	logic                             scan_end;
	logic                             need_res;
	logic                             stall;
	logic                             fire;
	logic                             res_set;
	logic [tkm_pkg::STREAM_W-1:0]     res_stream;
	logic                             res_done;
	logic                             cur_set;
	logic [tkm_pkg::STREAM_W-1:0]     cur_d;
	logic                             merging_d;

	tkm_wait_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tbl_cmd),
		.rd_idx (idx_q[tkm_pkg::IDX_W-1:0]),
		.stat   (tbl_stat)
	);

	assign in_req = tkm_pkg::req_t'(req.req_type);
	assign accept = req.valid && req.ready;

	always_comb begin
		case (in_req)
			tkm_pkg::REQ_LOAD: scan_need = !merging_q && (tbl_stat.count < tkm_pkg::FULL_COUNT);
			tkm_pkg::REQ_NEXT: scan_need = merging_q;
			default:           scan_need = 1'b0;
		endcase
	end

	// the shared comparator: stored key at idx_q against the request key
	assign rd_key   = tbl_stat.rd.key & tkm_pkg::KEY_MASK;
	assign key_gt   = rd_key > key_q;
	assign key_eq   = rd_key == key_q;
	// load stops past equal keys, next key stops at the first equal one
	assign scan_end = (idx_q == tbl_stat.count) || key_gt ||
		((req_q == tkm_pkg::REQ_NEXT) && key_eq);

	always_comb begin
		case (req_q)
			tkm_pkg::REQ_START: need_res = !merging_q;
			tkm_pkg::REQ_NEXT:  need_res = merging_q;
			tkm_pkg::REQ_END:   need_res = merging_q;
			default:            need_res = 1'b0;
		endcase
	end

	assign stall = need_res && out_valid_q && !res.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tkm_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = scan_need ? tkm_pkg::ST_SCAN : tkm_pkg::ST_EXEC;
				end
			end
			tkm_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = tkm_pkg::ST_EXEC;
				end
			end
			tkm_pkg::ST_EXEC: begin
				if (!stall) begin
					state_d = tkm_pkg::ST_IDLE;
				end
			end
			default: state_d = tkm_pkg::ST_IDLE;
		endcase
	end

	// outputs and execute actions
	always_comb begin
		req.ready    = (state_q == tkm_pkg::ST_IDLE);
		fire         = (state_q == tkm_pkg::ST_EXEC) && !stall;
		tbl_cmd      = '{op: tkm_pkg::TBL_NOP, pos: idx_q,
			entry: '{key: key_q, stream: sid_q}};
		res_set      = 1'b0;
		res_stream   = '0;
		res_done     = 1'b0;
		cur_set      = 1'b0;
		cur_d        = cur_q;
		merging_d    = merging_q;
		if (fire) begin
			case (req_q)
				tkm_pkg::REQ_LOAD: begin
					if (!merging_q && (tbl_stat.count < tkm_pkg::FULL_COUNT)) begin
						tbl_cmd.op = tkm_pkg::TBL_INSERT;
					end
				end
				tkm_pkg::REQ_START: begin
					if (!merging_q) begin
						res_set = 1'b1;
						if (tbl_stat.count == '0) begin
							res_done = 1'b1;
						end else begin
							tbl_cmd.op = tkm_pkg::TBL_POP;
							cur_set    = 1'b1;
							cur_d      = tbl_stat.head.stream;
							merging_d  = 1'b1;
							res_stream = tbl_stat.head.stream;
						end
					end
				end
				tkm_pkg::REQ_NEXT: begin
					if (merging_q) begin
						res_set    = 1'b1;
						res_stream = cur_q;
						// a key at or below every waiting key keeps the stream
						if ((idx_q != '0) && (tbl_stat.count < tkm_pkg::FULL_COUNT)) begin
							tbl_cmd.op           = tkm_pkg::TBL_REPLACE;
							tbl_cmd.entry.stream = cur_q;
							cur_set              = 1'b1;
							cur_d                = tbl_stat.head.stream;
							res_stream           = tbl_stat.head.stream;
						end
					end
				end
				tkm_pkg::REQ_END: begin
					if (merging_q) begin
						res_set = 1'b1;
						cur_set = 1'b1;
						if (tbl_stat.count != '0) begin
							tbl_cmd.op = tkm_pkg::TBL_POP;
							cur_d      = tbl_stat.head.stream;
							res_stream = tbl_stat.head.stream;
						end else begin
							cur_d     = '0;
							merging_d = 1'b0;
							res_done  = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tkm_pkg::ST_IDLE;
			idx_q       <= '0;
			cur_q       <= '0;
			merging_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			merging_q <= merging_d;
			if (cur_set) begin
				cur_q <= cur_d;
			end
			if (accept) begin
				idx_q <= '0;
			end else if ((state_q == tkm_pkg::ST_SCAN) && !scan_end) begin
				idx_q <= idx_q + 1'b1;
			end
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
			sid_q <= req.stream_id;
			key_q <= {req.key_hi, req.key_mid, req.key_lo} & tkm_pkg::KEY_MASK;
		end
		if (res_set) begin
			out_stream_q <= res_stream;
			out_done_q   <= res_done;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.emit_stream = out_stream_q;
	assign res.merge_done  = out_done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_stat.count <= tkm_pkg::FULL_COUNT)
		else $error("waiting count beyond table depth");

	a_merge_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		merging_q |-> (tbl_stat.count < tkm_pkg::FULL_COUNT))
		else $error("table full while merging");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tkm_pkg::ST_SCAN) |-> (idx_q <= tbl_stat.count))
		else $error("scan index past waiting count");

	a_end_reports_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(merging_q) |-> (out_valid_q && out_done_q && (out_stream_q == '0)))
		else $error("merge ended without a done result");

	a_done_no_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> (out_stream_q == '0))
		else $error("done result names a stream");

endmodule
